### src/plsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plsr_pkg
// Shared widths, codes and types of the paused linear set-point ramp.
// ----------------------------------------------------------------------------
package plsr_pkg;

  localparam int POS_W     = 24;
  localparam int TIME_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int SPEED_W   = 24;
  localparam int TOL_W     = 23;
  localparam int DIFF_W    = POS_W + 1;
  localparam int DSQ_W     = 2 * DIFF_W;
  localparam int MD_W      = POS_W + 1;
  localparam int USPS_W    = 20;
  localparam int DIV_W     = MD_W + USPS_W;
  localparam int PROG_W    = FRAC_W + 1;
  localparam int MUL_A_W   = TIME_W;
  localparam int MUL_B_W   = DIFF_W;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int SQRT_STEPS = DSQ_W / 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [USPS_W-1:0] US_PER_S = USPS_W'(1000000);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_ENABLE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_AT_END  = 3'd6;

  // multiplier operand selects
  localparam logic [2:0] M_NONE = 3'd0;
  localparam logic [2:0] M_TGT  = 3'd1;
  localparam logic [2:0] M_LAG  = 3'd2;
  localparam logic [2:0] M_TOL  = 3'd3;
  localparam logic [2:0] M_MD   = 3'd4;
  localparam logic [2:0] M_SPD  = 3'd5;
  localparam logic [2:0] M_LERP = 3'd6;

  // datapath actions
  localparam logic [4:0] A_NONE      = 5'd0;
  localparam logic [4:0] A_LOAD      = 5'd1;
  localparam logic [4:0] A_START     = 5'd2;
  localparam logic [4:0] A_ACC_FIRST = 5'd3;
  localparam logic [4:0] A_ACC       = 5'd4;
  localparam logic [4:0] A_SQ_INIT   = 5'd5;
  localparam logic [4:0] A_SQ_STEP   = 5'd6;
  localparam logic [4:0] A_MD        = 5'd7;
  localparam logic [4:0] A_PAUSE     = 5'd8;
  localparam logic [4:0] A_ACTIVE    = 5'd9;
  localparam logic [4:0] A_DIV_LATCH = 5'd10;
  localparam logic [4:0] A_REM       = 5'd11;
  localparam logic [4:0] A_ONE       = 5'd12;
  localparam logic [4:0] A_DIV_STEP  = 5'd13;
  localparam logic [4:0] A_PROG      = 5'd14;
  localparam logic [4:0] A_SET       = 5'd15;
  localparam logic [4:0] A_EMIT      = 5'd16;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic [TIME_W-1:0] time_t;

  typedef struct packed {
    logic [2:0] msel;
    logic [1:0] axis;
    logic [4:0] act;
    logic [1:0] waxis;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic started;
    logic paused;
    logic pause_enable;
    logic reach;
    logic out_busy;
    logic holding;
    logic completed;
  } stat_t;

  function automatic logic [DIFF_W-1:0] mag(input logic [DIFF_W-1:0] d);
    logic [DIFF_W-1:0] n;
    n = ~d + 1'b1;
    return d[DIFF_W-1] ? n : d;
  endfunction

  function automatic logic [DIFF_W-1:0] diff(input pos_t a, input pos_t b);
    return {a[POS_W-1], a} - {b[POS_W-1], b};
  endfunction

endpackage
`default_nettype wire

### src/plsr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plsr_in_if
// Input channel: item kind, device position and timestamp.
// ----------------------------------------------------------------------------
interface plsr_in_if
  import plsr_pkg::*;
;
  logic  valid;
  logic  ready;
  logic  kind;
  pos_t  pos_x;
  pos_t  pos_y;
  pos_t  pos_z;
  time_t now_us;

  modport source(output valid, kind, pos_x, pos_y, pos_z, now_us, input ready);
  modport sink(input valid, kind, pos_x, pos_y, pos_z, now_us, output ready);
endinterface
`default_nettype wire

### src/plsr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plsr_out_if
// Output channel: set point and ramp flags.
// ----------------------------------------------------------------------------
interface plsr_out_if
  import plsr_pkg::*;
;
  logic valid;
  logic ready;
  pos_t bead_x;
  pos_t bead_y;
  pos_t bead_z;
  logic is_paused;
  logic is_holding;
  logic is_completed;

  modport source(output valid, bead_x, bead_y, bead_z, is_paused, is_holding,
                 is_completed, input ready);
  modport sink(input valid, bead_x, bead_y, bead_z, is_paused, is_holding,
               is_completed, output ready);
endinterface
`default_nettype wire

### src/plsr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plsr_ctrl
// Sequencer: steps the datapath through distance, square root, pause test,
// progress division and interpolation for one word.
// ----------------------------------------------------------------------------
module plsr_ctrl
  import plsr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_LOADED   = 5'd1;
  localparam logic [4:0] S_TSQ      = 5'd2;
  localparam logic [4:0] S_TSQ_END  = 5'd3;
  localparam logic [4:0] S_SQ_INIT  = 5'd4;
  localparam logic [4:0] S_SQRT     = 5'd5;
  localparam logic [4:0] S_MD       = 5'd6;
  localparam logic [4:0] S_PSQ      = 5'd7;
  localparam logic [4:0] S_PSQ_END  = 5'd8;
  localparam logic [4:0] S_PCMP     = 5'd9;
  localparam logic [4:0] S_PCHK     = 5'd10;
  localparam logic [4:0] S_PMUL     = 5'd11;
  localparam logic [4:0] S_PMUL2    = 5'd12;
  localparam logic [4:0] S_PREM     = 5'd13;
  localparam logic [4:0] S_PREACH   = 5'd14;
  localparam logic [4:0] S_DIV      = 5'd15;
  localparam logic [4:0] S_DIVEND   = 5'd16;
  localparam logic [4:0] S_LERP     = 5'd17;
  localparam logic [4:0] S_LERP_END = 5'd18;
  localparam logic [4:0] S_OUT      = 5'd19;

  logic [4:0] state, state_next;
  logic [4:0] cnt, cnt_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '{msel: M_NONE, axis: 2'd0, act: A_NONE, waxis: 2'd0};
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.act    = A_LOAD;
          state_next = S_LOADED;
        end
      end
      S_LOADED: begin
        cnt_next = '0;
        priority if (!st.kind) begin
          cmd.act    = A_START;
          state_next = S_TSQ;
        end else if (!st.started) begin
          state_next = S_OUT;
        end else if (st.pause_enable) begin
          state_next = S_PSQ;
        end else if (st.paused) begin
          state_next = S_OUT;
        end else begin
          state_next = S_PMUL;
        end
      end
      S_TSQ, S_PSQ: begin
        cmd.msel = (state == S_TSQ) ? M_TGT : M_LAG;
        cmd.axis = cnt[1:0];
        if (cnt != '0) begin
          cmd.act = (cnt == 5'd1) ? A_ACC_FIRST : A_ACC;
        end
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd2) begin
          state_next = (state == S_TSQ) ? S_TSQ_END : S_PSQ_END;
        end
      end
      S_TSQ_END: begin
        cmd.act    = A_ACC;
        state_next = S_SQ_INIT;
      end
      S_SQ_INIT: begin
        cmd.act    = A_SQ_INIT;
        cnt_next   = '0;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.act  = A_SQ_STEP;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(SQRT_STEPS - 1)) begin
          state_next = S_MD;
        end
      end
      S_MD: begin
        cmd.act    = A_MD;
        state_next = S_PMUL;
      end
      S_PSQ_END: begin
        cmd.act    = A_ACC;
        cmd.msel   = M_TOL;
        state_next = S_PCMP;
      end
      S_PCMP: begin
        cmd.act    = A_PAUSE;
        state_next = S_PCHK;
      end
      S_PCHK: begin
        state_next = st.paused ? S_OUT : S_PMUL;
      end
      S_PMUL: begin
        cmd.msel   = M_MD;
        cmd.act    = A_ACTIVE;
        state_next = S_PMUL2;
      end
      S_PMUL2: begin
        cmd.msel   = M_SPD;
        cmd.act    = A_DIV_LATCH;
        state_next = S_PREM;
      end
      S_PREM: begin
        cmd.act    = A_REM;
        state_next = S_PREACH;
      end
      S_PREACH: begin
        cnt_next = '0;
        if (st.reach) begin
          cmd.act    = A_ONE;
          state_next = S_LERP;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.act  = A_DIV_STEP;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(FRAC_W - 1)) begin
          state_next = S_DIVEND;
        end
      end
      S_DIVEND: begin
        cmd.act    = A_PROG;
        cnt_next   = '0;
        state_next = S_LERP;
      end
      S_LERP: begin
        // multiply one axis, write back the previous one
        cmd.msel  = M_LERP;
        cmd.axis  = cnt[1:0];
        cmd.waxis = cnt[1:0] - 2'd1;
        if (cnt != '0) begin
          cmd.act = A_SET;
        end
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd2) begin
          state_next = S_LERP_END;
        end
      end
      S_LERP_END: begin
        cmd.act    = A_SET;
        cmd.waxis  = 2'd2;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!st.out_busy) begin
          cmd.act    = A_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule
`default_nettype wire

### src/plsr_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plsr_dp
// Datapath: configuration, ramp state, shared multiplier, square root and
// division steps, interpolation and the output register.
// ----------------------------------------------------------------------------
module plsr_dp
  import plsr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_kind,
  input  pos_t                  in_pos_x,
  input  pos_t                  in_pos_y,
  input  pos_t                  in_pos_z,
  input  time_t                 in_now,
  input  cmd_t                  cmd,
  output stat_t                 st,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pos_t                  out_x,
  output pos_t                  out_y,
  output pos_t                  out_z,
  output logic                  out_paused,
  output logic                  out_holding,
  output logic                  out_completed
);

  // configuration
  pos_t               tgt [3];
  logic [SPEED_W-1:0] spd;
  logic [TOL_W-1:0]   tol;
  logic               pen;
  logic               hold;

  // ramp state
  pos_t            src  [3];
  pos_t            setp [3];
  time_t           start_t;
  time_t           pst;
  time_t           ptot;
  logic [MD_W-1:0] md;
  logic            started;
  logic            paused;
  logic            holding;
  logic            completed;

  // latched word and work registers
  logic               kind_r;
  pos_t               pos [3];
  time_t              now_r;
  logic [DSQ_W-1:0]   acc;
  logic [DSQ_W-1:0]   rem;
  logic [DSQ_W-1:0]   res;
  logic [DSQ_W-1:0]   bitv;
  time_t              active;
  logic [DIV_W-1:0]   divr;
  logic [MUL_P_W-1:0] r;
  logic [FRAC_W-1:0]  q;
  logic [PROG_W-1:0]  prog;
  logic [MUL_P_W-1:0] mul_p;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [DIFF_W-1:0]  d_tgt, d_lag, d_w;
  logic [DSQ_W-1:0]   sq_try;
  logic [MUL_P_W-1:0] r2;
  logic [MUL_P_W-1:0] rnd_full;
  logic [DIFF_W-1:0]  rnd;
  logic [DIFF_W-1:0]  new_sp;
  logic               lag;

  assign d_tgt    = diff(tgt[cmd.axis], src[cmd.axis]);
  assign d_lag    = diff(pos[cmd.axis], setp[cmd.axis]);
  assign d_w      = diff(tgt[cmd.waxis], src[cmd.waxis]);
  assign sq_try   = res + bitv;
  assign r2       = {r[MUL_P_W-2:0], 1'b0};
  assign rnd_full = mul_p + (MUL_P_W'(1) << (FRAC_W - 1));
  assign rnd      = rnd_full[FRAC_W +: DIFF_W];
  assign new_sp   = d_w[DIFF_W-1] ? ({src[cmd.waxis][POS_W-1], src[cmd.waxis]} - rnd)
                                  : ({src[cmd.waxis][POS_W-1], src[cmd.waxis]} + rnd);
  assign lag      = acc > DSQ_W'(mul_p);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.msel)
      M_TGT: begin
        mul_a = MUL_A_W'(mag(d_tgt));
        mul_b = mag(d_tgt);
      end
      M_LAG: begin
        mul_a = MUL_A_W'(mag(d_lag));
        mul_b = mag(d_lag);
      end
      M_TOL: begin
        mul_a = MUL_A_W'(tol);
        mul_b = MUL_B_W'(tol);
      end
      M_MD: begin
        mul_a = MUL_A_W'(US_PER_S);
        mul_b = md;
      end
      M_SPD: begin
        // zero speed runs as one LSB
        mul_a = active;
        mul_b = (spd == '0) ? MUL_B_W'(1) : MUL_B_W'(spd);
      end
      M_LERP: begin
        mul_a = MUL_A_W'(prog);
        mul_b = mag(d_tgt);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    unique case (cmd.act)
      A_LOAD: begin
        kind_r <= in_kind;
        pos[0] <= in_pos_x;
        pos[1] <= in_pos_y;
        pos[2] <= in_pos_z;
        now_r  <= in_now;
      end
      A_ACC_FIRST: acc <= DSQ_W'(mul_p);
      A_ACC:       acc <= acc + DSQ_W'(mul_p);
      A_SQ_INIT: begin
        rem  <= acc;
        res  <= '0;
        bitv <= DSQ_W'(1) << (DSQ_W - 2);
      end
      A_SQ_STEP: begin
        if (rem >= sq_try) begin
          rem <= rem - sq_try;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
      end
      A_ACTIVE:    active <= now_r - start_t - ptot;
      A_DIV_LATCH: divr <= mul_p[DIV_W-1:0];
      A_REM: begin
        r <= mul_p;
        q <= '0;
      end
      A_DIV_STEP: begin
        if (r2 >= MUL_P_W'(divr)) begin
          r <= r2 - MUL_P_W'(divr);
          q <= {q[FRAC_W-2:0], 1'b1};
        end else begin
          r <= r2;
          q <= {q[FRAC_W-2:0], 1'b0};
        end
      end
      A_PROG: prog <= {1'b0, q};
      A_ONE:  prog <= PROG_W'(1) << FRAC_W;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tgt[0] <= '0;
      tgt[1] <= '0;
      tgt[2] <= '0;
      spd    <= SPEED_W'(256);
      tol    <= TOL_W'(3840);
      pen    <= 1'b1;
      hold   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_X:     tgt[0] <= cfg_data[POS_W-1:0];
        REG_TARGET_Y:     tgt[1] <= cfg_data[POS_W-1:0];
        REG_TARGET_Z:     tgt[2] <= cfg_data[POS_W-1:0];
        REG_SPEED:        spd    <= cfg_data[SPEED_W-1:0];
        REG_TOLERANCE:    tol    <= cfg_data[TOL_W-1:0];
        REG_PAUSE_ENABLE: pen    <= cfg_data[0];
        REG_HOLD_AT_END:  hold   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src[0]    <= '0;
      src[1]    <= '0;
      src[2]    <= '0;
      setp[0]   <= '0;
      setp[1]   <= '0;
      setp[2]   <= '0;
      start_t   <= '0;
      pst       <= '0;
      ptot      <= '0;
      md        <= '0;
      started   <= 1'b0;
      paused    <= 1'b0;
      holding   <= 1'b0;
      completed <= 1'b0;
    end else begin
      unique case (cmd.act)
        A_START: begin
          src[0]    <= pos[0];
          src[1]    <= pos[1];
          src[2]    <= pos[2];
          setp[0]   <= pos[0];
          setp[1]   <= pos[1];
          setp[2]   <= pos[2];
          start_t   <= now_r;
          pst       <= '0;
          ptot      <= '0;
          started   <= 1'b1;
          paused    <= 1'b0;
          holding   <= 1'b0;
          completed <= 1'b0;
        end
        A_MD: md <= res[MD_W-1:0];
        A_PAUSE: begin
          priority if (!paused && lag) begin
            paused <= 1'b1;
            pst    <= now_r;
          end else if (paused && !lag) begin
            paused <= 1'b0;
            ptot   <= ptot + now_r - pst;
          end
        end
        A_ONE: begin
          if (hold) begin
            holding <= 1'b1;
          end else begin
            completed <= 1'b1;
          end
        end
        A_SET: setp[cmd.waxis] <= new_sp[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // output register: hold the word until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.act == A_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.act == A_EMIT) begin
      out_x         <= setp[0];
      out_y         <= setp[1];
      out_z         <= setp[2];
      out_paused    <= paused;
      out_holding   <= holding;
      out_completed <= completed;
    end
  end

  assign st.kind         = kind_r;
  assign st.started      = started;
  assign st.paused       = paused;
  assign st.pause_enable = pen;
  assign st.reach        = r >= MUL_P_W'(divr);
  assign st.out_busy     = out_valid && !out_ready;
  assign st.holding      = holding;
  assign st.completed    = completed;

endmodule
`default_nettype wire

### src/paused_linear_setpoint_ramp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// paused_linear_setpoint_ramp
// Three-axis set-point ramp with pause on device lag.
// ----------------------------------------------------------------------------
// Usage: in_ch carries one word per servo tick (kind 0 starts a move from the
// given point, kind 1 is an ordinary tick with the device position); out_ch
// returns one word per input: the set point and the paused, holding and
// completed flags. The cfg port writes the target, speed, tolerance and mode
// registers; the user must do it only while the block is idle (not enforced).
// Flow: a tick goes through the pause test over the shared multiplier when
// pausing is on, a 16-step progress division (skipped once progress has
// reached its end) and three interpolation products; a start word adds the
// 25-step square root of the move distance. A tick that pauses ends after the
// pause test; a tick before any start, or a paused tick with pausing off, goes
// straight to the output register. One word is in work at a time; the next is
// accepted once the result is registered.
// Reset clears all ramp state, loads the register defaults and empties the
// output register. When the receiver stalls, the finished word waits in the
// output register; the next input word is still accepted and worked on, and
// waits at its end until the output register frees.
// ----------------------------------------------------------------------------
module paused_linear_setpoint_ramp
  import plsr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  plsr_in_if.sink               in_ch,
  plsr_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t st;

  plsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  plsr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_kind       (in_ch.kind),
    .in_pos_x      (in_ch.pos_x),
    .in_pos_y      (in_ch.pos_y),
    .in_pos_z      (in_ch.pos_z),
    .in_now        (in_ch.now_us),
    .cmd           (cmd),
    .st            (st),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_x         (out_ch.bead_x),
    .out_y         (out_ch.bead_y),
    .out_z         (out_ch.bead_z),
    .out_paused    (out_ch.is_paused),
    .out_holding   (out_ch.is_holding),
    .out_completed (out_ch.is_completed)
  );

  a_end_flags: assert property (@(posedge clk) disable iff (rst)
    !(st.holding && st.completed))
    else $error("holding and completed both set");

  a_pause_needs_start: assert property (@(posedge clk) disable iff (rst)
    st.paused |-> st.started)
    else $error("paused without a started move");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !$rose(out_ch.valid))
    else $error("result word appeared one cycle after acceptance");

endmodule
`default_nettype wire
